/* src/dls_pkg.sv */
// Package for the dense layer with sigmoid: widths, codes, cell control type
// and the sigmoid lookup table built at elaboration.
// No dependencies.
`default_nettype none

package dls_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int DIM_CNT_W   = $clog2(MAX_DIM + 1);
  localparam int WADDR_W     = 2 * DIM_W;
  localparam int WS_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ACC_W       = 40;
  localparam int RES_W       = 16;
  localparam int ROW_W       = 16;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_ELEM   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ACTIVATION = 2'd2;

  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef logic [RES_W-1:0] sig_tab_t [SIG_ENTRIES];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] num, input logic [63:0] den);
    longint sum;
    logic [63:0] term;
    sum = longint'(Q32_ONE);
    term = Q32_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(term * num, den * 64'(k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    logic [63:0] e1;
    logic [63:0] ap;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] y;
    longint p;
    e1 = exp_neg_q32(64'd1, 64'd1);
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      p = 16 * longint'(i) - 8 * longint'(SIG_ENTRIES);
      ap = (p < 0) ? 64'(-p) : 64'(p);
      n = ap / SIG_ENTRIES;
      e = exp_neg_q32(ap % SIG_ENTRIES, 64'(SIG_ENTRIES));
      while (n > 0) begin
        e = (e * e1) >> 32;
        n = n - 64'd1;
      end
      d = Q32_ONE + e;
      num = (p >= 0) ? (64'd256 << 32) : 64'd256 * e;
      y = udiv64(64'd2 * num + d, 64'd2 * d);
      tab[i] = y[RES_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

/* src/dls_weight_ram.sv */
// Weight store: one write port, one registered read port.
// Depends on dls_pkg.
`default_nettype none

module dls_weight_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [dls_pkg::WADDR_W-1:0] waddr,
  input  wire logic [dls_pkg::VAL_W-1:0]   wdata,
  input  wire logic                        re,
  input  wire logic [dls_pkg::WADDR_W-1:0] raddr,
  output logic      [dls_pkg::VAL_W-1:0]   rdata_r
);
  import dls_pkg::*;

  logic [VAL_W-1:0] mem [WS_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/dls_acc_cell.sv */
// One accumulator cell of the rotating ring; takes its neighbor's sum on a shift,
// optionally adding a product. Depends on dls_pkg.
`default_nettype none

module dls_acc_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dls_pkg::cell_ctrl_t              ctrl,
  input  wire logic                             add_en,
  input  wire logic signed [dls_pkg::ACC_W-1:0] addend,
  input  wire logic signed [dls_pkg::ACC_W-1:0] nb_in,
  output logic signed      [dls_pkg::ACC_W-1:0] acc
);
  import dls_pkg::*;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift) begin
      acc_nxt = nb_in + (add_en ? addend : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* src/dls_finish.sv */
// Row-end finishing: round the sum to Q8.8, saturate, and pick the sigmoid
// entry or the plain value. Depends on dls_pkg (SIG_TABLE).
`default_nettype none

module dls_finish (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire logic signed [dls_pkg::ACC_W-1:0] acc,
  input  wire logic                             use_act,
  output logic signed      [dls_pkg::RES_W-1:0] result
);
  import dls_pkg::*;

  localparam int RND_SH = 8;
  localparam int V_W    = ACC_W - RND_SH;
  localparam logic signed [V_W-1:0] SAT_HI  = V_W'(32767);
  localparam logic signed [V_W-1:0] SAT_LO  = -V_W'(32768);
  localparam logic signed [V_W-1:0] CLIP_HI = V_W'(2047);
  localparam logic signed [V_W-1:0] CLIP_LO = -V_W'(2048);

  logic signed [ACC_W-1:0] t;
  logic signed [V_W-1:0]   v;
  logic [11:0]             c;
  logic [RES_W-1:0]        sat_nxt;
  logic [SIG_IDX_W-1:0]    idx_nxt;
  logic [RES_W-1:0]        sat_r;
  logic [SIG_IDX_W-1:0]    idx_r;

  always_comb begin
    t = acc + ACC_W'(128);
    v = t[ACC_W-1:RND_SH];
    c = v[11:0] + 12'd2048;
    if (v > SAT_HI) begin
      sat_nxt = 16'h7fff;
    end else if (v < SAT_LO) begin
      sat_nxt = 16'h8000;
    end else begin
      sat_nxt = v[RES_W-1:0];
    end
    if (v < CLIP_LO) begin
      idx_nxt = '0;
    end else if (v > CLIP_HI) begin
      idx_nxt = '1;
    end else begin
      idx_nxt = c[11 -: SIG_IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sat_r <= sat_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign result = use_act ? SIG_TABLE[idx_r] : sat_r;

endmodule

`default_nettype wire

/* src/dense_layer_sigmoid_unit.sv */
// Top level of the dense layer with sigmoid: control, weight store, ring of
// accumulator cells and row-end finishing. Depends on dls_pkg, dls_weight_ram,
// dls_acc_cell and dls_finish.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | in_op, in_weight_row, in_weight_col, in_value
//   out     | out_valid/out_ready| out_row_number, out_col_number, out_result, out_last
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// A weight beat is written to the weight store as it is accepted. For an element
// beat the weight memory is read once per column, 16 reads, and the products
// rotate through the ring of 16 cells, one multiply-accumulate per cycle, behind
// the registered read and the registered product. A row end passes ST_EMIT_CALC
// and ST_EMIT_OUT once per output column, plus any time the output register
// waits on out_ready. Reset clears the cells and counters; the weight store is not
// cleared. The block takes the next beat while the last result still waits.
`default_nettype none

module dense_layer_sigmoid_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_op,
  input  wire logic        [dls_pkg::DIM_W-1:0]    in_weight_row,
  input  wire logic        [dls_pkg::DIM_W-1:0]    in_weight_col,
  input  wire logic signed [dls_pkg::VAL_W-1:0]    in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [dls_pkg::ROW_W-1:0]    out_row_number,
  output logic             [dls_pkg::DIM_W-1:0]    out_col_number,
  output logic signed      [dls_pkg::RES_W-1:0]    out_result,
  output logic                                     out_last,
  input  wire logic                                cfg_we,
  input  wire logic        [dls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [dls_pkg::CFG_W-1:0]    cfg_data
);
  import dls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT_CALC,
    ST_EMIT_OUT
  } state_t;

  localparam int MAC_LAT = 2;
  localparam int CYC_W   = $clog2(MAX_DIM + MAC_LAT);
  localparam logic [CYC_W-1:0] CYC_LAST  = CYC_W'(MAX_DIM + MAC_LAT - 1);
  localparam logic [CYC_W-1:0] CYC_SHIFT = CYC_W'(MAC_LAT);
  localparam logic [CYC_W-1:0] CYC_READS = CYC_W'(MAX_DIM);

  state_t                  state_r;
  logic [CYC_W-1:0]        cyc_r;
  logic signed [VAL_W-1:0] value_r;
  logic [DIM_W-1:0]        elem_cnt_r;
  logic [ROW_W-1:0]        row_cnt_r;
  logic [DIM_W-1:0]        col_r;
  logic [CFG_W-1:0]        inner_size_r;
  logic [CFG_W-1:0]        out_cols_r;
  logic                    use_act_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic [DIM_W-1:0]        out_col_r;
  logic signed [RES_W-1:0] out_result_r;
  logic                    out_last_r;

  logic                    in_acc;
  logic                    ram_we;
  logic                    ram_re;
  logic [WADDR_W-1:0]      ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;
  logic                    mac_shift;
  logic                    out_free;
  logic                    emit_load;
  logic                    col_last;
  logic                    row_end;
  logic [DIM_CNT_W-1:0]    eff_inner;
  logic [DIM_CNT_W-1:0]    eff_out;
  cell_ctrl_t              cell_ctrl;
  logic signed [ACC_W-1:0] cell_acc [MAX_DIM];
  logic signed [ACC_W-1:0] addend;
  logic signed [RES_W-1:0] fin_result;

  always_comb begin
    if (inner_size_r == '0) begin
      eff_inner = DIM_CNT_W'(1);
    end else if (inner_size_r > CFG_W'(MAX_DIM)) begin
      eff_inner = DIM_CNT_W'(MAX_DIM);
    end else begin
      eff_inner = DIM_CNT_W'(inner_size_r);
    end
    if (out_cols_r == '0) begin
      eff_out = DIM_CNT_W'(1);
    end else if (out_cols_r > CFG_W'(MAX_DIM)) begin
      eff_out = DIM_CNT_W'(MAX_DIM);
    end else begin
      eff_out = DIM_CNT_W'(out_cols_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_op == OP_WEIGHT);
  assign ram_re    = (state_r == ST_MAC) && (cyc_r < CYC_READS);
  assign ram_raddr = {elem_cnt_r, cyc_r[DIM_W-1:0]};
  assign mac_shift = (state_r == ST_MAC) && (cyc_r >= CYC_SHIFT);
  assign out_free  = !out_valid_r || out_ready;
  assign emit_load = (state_r == ST_EMIT_OUT) && out_free;
  assign col_last  = ({1'b0, col_r} + DIM_CNT_W'(1)) == eff_out;
  assign row_end   = ({1'b0, elem_cnt_r} + DIM_CNT_W'(1)) >= eff_inner;
  assign addend    = ACC_W'(prod_r);

  always_comb begin
    cell_ctrl.shift = mac_shift || (state_r == ST_EMIT_CALC);
    cell_ctrl.clear = emit_load && col_last;
  end

  dls_weight_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   ({in_weight_row, in_weight_col}),
    .wdata   (in_value),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    localparam int NB = (g + 1) % MAX_DIM;
    localparam bit IS_TAIL = (g == MAX_DIM - 1);
    dls_acc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (cell_ctrl),
      .add_en (IS_TAIL && (state_r == ST_MAC)),
      .addend (addend),
      .nb_in  (cell_acc[NB]),
      .acc    (cell_acc[g])
    );
  end

  dls_finish u_finish (
    .clk     (clk),
    .load    (state_r == ST_EMIT_CALC),
    .acc     (cell_acc[0]),
    .use_act (use_act_r),
    .result  (fin_result)
  );

  always_ff @(posedge clk) begin
    prod_r <= value_r * $signed(ram_rdata);
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cyc_r        <= '0;
      elem_cnt_r   <= '0;
      row_cnt_r    <= '0;
      col_r        <= '0;
      inner_size_r <= CFG_W'(2);
      out_cols_r   <= CFG_W'(1);
      use_act_r    <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INNER_SIZE:     inner_size_r <= cfg_data;
          CFG_OUT_COLS:       out_cols_r   <= cfg_data;
          CFG_USE_ACTIVATION: use_act_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !emit_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_op == OP_ELEM)) begin
            value_r <= in_value;
            cyc_r   <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          cyc_r <= cyc_r + CYC_W'(1);
          if (cyc_r == CYC_LAST) begin
            if (row_end) begin
              elem_cnt_r <= '0;
              col_r      <= '0;
              state_r    <= ST_EMIT_CALC;
            end else begin
              elem_cnt_r <= elem_cnt_r + DIM_W'(1);
              state_r    <= ST_IDLE;
            end
          end
        end
        ST_EMIT_CALC: begin
          state_r <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_row_r    <= row_cnt_r;
            out_col_r    <= col_r;
            out_result_r <= fin_result;
            out_last_r   <= col_last;
            if (col_last) begin
              row_cnt_r <= row_cnt_r + ROW_W'(1);
              state_r   <= ST_IDLE;
            end else begin
              col_r   <= col_r + DIM_W'(1);
              state_r <= ST_EMIT_CALC;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_number = out_row_r;
  assign out_col_number = out_col_r;
  assign out_result     = out_result_r;
  assign out_last       = out_last_r;

  a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (cyc_r <= CYC_LAST))
    else $error("mac cycle counter ran past the last ring shift");

  a_row_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && col_last) |=> (row_cnt_r == $past(row_cnt_r) + ROW_W'(1)))
    else $error("row counter did not advance at the last column");

  a_ring_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && col_last) |=> ((cell_acc[0] == '0) && (state_r == ST_IDLE)))
    else $error("accumulators not cleared after the row");

endmodule

`default_nettype wire
